[sv/pfx_pkg.sv]
package pfx_pkg;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int RESULT_W = 32;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEFT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd4;

  localparam logic [1:0] RD_TOP1 = 2'd0;
  localparam logic [1:0] RD_TOP2 = 2'd1;
  localparam logic [1:0] RD_BASE = 2'd2;

  typedef struct packed {
    logic                latch_in;
    logic                acc_digit;
    logic                push;
    logic                push_sel_acc;
    logic                clear_num;
    logic                set_err;
    logic [STATUS_W-1:0] err_code;
    logic                rd_en;
    logic [1:0]          rd_sel;
    logic                latch_b;
    logic                latch_a;
    logic                exec;
    logic                step;
    logic                load_base;
    logic                out_load;
    logic                clear_all;
  } pfx_cmd_t;

  typedef struct packed {
    logic end_expr;
    logic is_digit;
    logic is_space;
    logic is_mul;
    logic is_div;
    logic in_num;
    logic err_set;
    logic cnt_lt2;
    logic cnt_zero;
    logic cnt_one;
    logic b_zero;
    logic out_free;
  } pfx_stat_t;

endpackage

[sv/pfx_in_if.sv]
interface pfx_in_if;
  import pfx_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_expression;

  modport source (output valid, output char_code, output end_of_expression, input ready);
  modport sink (input valid, input char_code, input end_of_expression, output ready);

endinterface

[sv/pfx_out_if.sv]
interface pfx_out_if;
  import pfx_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result_value;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);

endinterface

[sv/postfix_expression_evaluator_top.sv]
// A digit or a skipped character is handled in decode; a space or an operator that finds
// fewer than two operands also passes the operand check; an add, subtract or unknown operator
// reads both operands, executes and pushes, and a multiply or divide also iterates in the
// shift-and-add / restoring-divide unit. An end beat may wait for the result register to drain.
// One beat is in work at a time; the next is taken while a result waits to be read.
// Reset (synchronous, active low) empties the stack, clears the error and drops out valid.
module postfix_expression_evaluator_top
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input logic      clk,
  input logic      rst_n,
  pfx_in_if.sink   in_chan,
  pfx_out_if.source out_chan
);

  pfx_cmd_t  cmd;
  pfx_stat_t stat;
  logic      in_ready;

  assign in_chan.ready = in_ready;

  pfx_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfx_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char          (in_chan.char_code),
    .in_end           (in_chan.end_of_expression),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_result_value (out_chan.result_value),
    .out_status       (out_chan.status)
  );

endmodule

[sv/pfx_ram.sv]
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/pfx_dpath.sv]
module pfx_dpath
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [CHAR_W-1:0]          in_char,
  input  logic                       in_end,
  input  pfx_cmd_t                   cmd,
  output pfx_stat_t                  stat,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [RESULT_W-1:0] out_result_value,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int W  = DATA_WIDTH;

  logic [CHAR_W-1:0]   ch_r;
  logic                end_r;
  logic [CW-1:0]       count_r;
  logic [W-1:0]        accum_r;
  logic                in_num_r;
  logic [STATUS_W-1:0] err_r;
  logic [W-1:0]        a_r;
  logic [W-1:0]        b_r;
  logic [W-1:0]        p_r;
  logic                neg_r;
  logic                out_valid_r;
  logic [RESULT_W-1:0] out_value_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                full;
  logic                is_mul;
  logic                is_div;
  logic [CW-1:0]       top1;
  logic [CW-1:0]       top2;
  logic [AW-1:0]       raddr;
  logic [W-1:0]        rdata;
  logic                we;
  logic [W-1:0]        wdata;
  logic [W-1:0]        res_val;
  logic [W:0]          rem_sh;
  logic [W:0]          rem_diff;
  logic [RESULT_W-1:0] p_wide;

  assign full   = (count_r == CW'(STACK_DEPTH));
  assign is_mul = (ch_r == CH_STAR);
  assign is_div = (ch_r == CH_SLASH);
  assign top1   = count_r - CW'(1);
  assign top2   = count_r - CW'(2);

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP1: raddr = top1[AW-1:0];
      RD_TOP2: raddr = top2[AW-1:0];
      RD_BASE: raddr = '0;
      default: raddr = '0;
    endcase
  end

  assign res_val = is_div ? (neg_r ? (W'(0) - a_r) : a_r) : p_r;
  assign we      = cmd.push && !full;
  assign wdata   = cmd.push_sel_acc ? accum_r : res_val;

  assign rem_sh   = {p_r, a_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, b_r};

  pfx_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  generate
    if (DATA_WIDTH >= RESULT_W) begin : g_trunc
      assign p_wide = p_r[RESULT_W-1:0];
    end else begin : g_ext
      assign p_wide = {{(RESULT_W - DATA_WIDTH){1'b0}}, p_r};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      ch_r  <= in_char;
      end_r <= in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      accum_r  <= '0;
      in_num_r <= 1'b0;
      err_r    <= ST_OK;
    end else if (cmd.clear_all) begin
      count_r  <= '0;
      accum_r  <= '0;
      in_num_r <= 1'b0;
      err_r    <= ST_OK;
    end else begin
      if (cmd.acc_digit) begin
        accum_r  <= (accum_r << 3) + (accum_r << 1) + W'(ch_r[3:0]);
        in_num_r <= 1'b1;
      end
      if (cmd.clear_num) begin
        accum_r  <= '0;
        in_num_r <= 1'b0;
      end
      if (cmd.push && full && err_r == ST_OK) begin
        err_r <= ST_OVER;
      end
      if (cmd.set_err && err_r == ST_OK) begin
        err_r <= cmd.err_code;
      end
      if (we) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.latch_a) begin
        count_r <= top2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_b) begin
      b_r <= rdata;
    end
    if (cmd.latch_a) begin
      a_r <= rdata;
    end
    if (cmd.load_base) begin
      p_r <= rdata;
    end
    if (cmd.exec) begin
      case (ch_r)
        CH_PLUS:  p_r <= a_r + b_r;
        CH_MINUS: p_r <= a_r - b_r;
        CH_STAR:  p_r <= '0;
        CH_SLASH: begin
          p_r   <= '0;
          neg_r <= a_r[W-1] ^ b_r[W-1];
          a_r   <= a_r[W-1] ? (W'(0) - a_r) : a_r;
          b_r   <= b_r[W-1] ? (W'(0) - b_r) : b_r;
        end
        default:  p_r <= '0;
      endcase
    end
    if (cmd.step) begin
      if (is_mul) begin
        if (b_r[0]) begin
          p_r <= p_r + a_r;
        end
        a_r <= a_r << 1;
        b_r <= b_r >> 1;
      end else if (!rem_diff[W]) begin
        p_r <= rem_diff[W-1:0];
        a_r <= {a_r[W-2:0], 1'b1};
      end else begin
        p_r <= rem_sh[W-1:0];
        a_r <= {a_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r  <= (err_r == ST_OK) ? p_wide : '0;
      out_status_r <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_value_r);
  assign out_status       = out_status_r;

  assign stat.end_expr = end_r;
  assign stat.is_digit = (ch_r >= CH_0) && (ch_r <= CH_9);
  assign stat.is_space = (ch_r == CH_SPACE);
  assign stat.is_mul   = is_mul;
  assign stat.is_div   = is_div;
  assign stat.in_num   = in_num_r;
  assign stat.err_set  = (err_r != ST_OK);
  assign stat.cnt_lt2  = (count_r < CW'(2));
  assign stat.cnt_zero = (count_r == '0);
  assign stat.cnt_one  = (count_r == CW'(1));
  assign stat.b_zero   = (b_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

[sv/pfx_ctrl.sv]
module pfx_ctrl
  import pfx_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pfx_stat_t stat,
  output pfx_cmd_t  cmd
);

  localparam int IW = $clog2(DATA_WIDTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CLOSE  = 4'd2;
  localparam logic [3:0] S_OPCHK  = 4'd3;
  localparam logic [3:0] S_RDB    = 4'd4;
  localparam logic [3:0] S_RDA    = 4'd5;
  localparam logic [3:0] S_EXEC   = 4'd6;
  localparam logic [3:0] S_ITER   = 4'd7;
  localparam logic [3:0] S_PUSH   = 4'd8;
  localparam logic [3:0] S_ENDCHK = 4'd9;
  localparam logic [3:0] S_RD0    = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;

  logic [3:0]    state_r;
  logic [3:0]    state_nxt;
  logic [IW-1:0] iter_r;
  logic [IW-1:0] iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.end_expr) begin
          if (stat.err_set) begin
            state_nxt = S_FINISH;
          end else if (stat.in_num) begin
            state_nxt = S_CLOSE;
          end else begin
            state_nxt = S_ENDCHK;
          end
        end else if (stat.err_set) begin
          state_nxt = S_IDLE;
        end else if (stat.is_digit) begin
          cmd.acc_digit = 1'b1;
          state_nxt     = S_IDLE;
        end else if (stat.in_num) begin
          state_nxt = S_CLOSE;
        end else begin
          state_nxt = S_OPCHK;
        end
      end
      S_CLOSE: begin
        cmd.push         = 1'b1;
        cmd.push_sel_acc = 1'b1;
        cmd.clear_num    = 1'b1;
        state_nxt        = stat.end_expr ? S_ENDCHK : S_OPCHK;
      end
      S_OPCHK: begin
        if (stat.err_set || stat.is_space) begin
          state_nxt = S_IDLE;
        end else if (stat.cnt_lt2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNDER;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TOP1;
          state_nxt  = S_RDB;
        end
      end
      S_RDB: begin
        cmd.latch_b = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_TOP2;
        state_nxt   = S_RDA;
      end
      S_RDA: begin
        cmd.latch_a = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_div && stat.b_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZ;
          state_nxt    = S_IDLE;
        end else begin
          cmd.exec  = 1'b1;
          iter_nxt  = '0;
          state_nxt = (stat.is_mul || stat.is_div) ? S_ITER : S_PUSH;
        end
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (iter_r == IW'(DATA_WIDTH - 1)) begin
          state_nxt = S_PUSH;
        end else begin
          iter_nxt = iter_r + IW'(1);
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ENDCHK: begin
        if (stat.err_set) begin
          state_nxt = S_FINISH;
        end else if (stat.cnt_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNDER;
          state_nxt    = S_FINISH;
        end else if (!stat.cnt_one) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_LEFT;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BASE;
          state_nxt  = S_RD0;
        end
      end
      S_RD0: begin
        cmd.load_base = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.clear_all = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sv/pfx_checker.sv]
module pfx_checker
  import pfx_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [RESULT_W-1:0] out_result_value,
  input logic [STATUS_W-1:0]        out_status
);

  // A result waiting for its reader keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_value) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_UNDER ||
                   out_status == ST_OVER || out_status == ST_LEFT ||
                   out_status == ST_DIVZ))
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_value == '0)
    else $error("failed expression reported a non-zero value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator_top pfx_checker u_pfx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_result_value (out_chan.result_value),
  .out_status       (out_chan.status)
);
